// ===== src/mcrc_pkg.sv =====
// mcrc_pkg: shared types, register indexes, polynomials and byte-fold functions
// for the multi-width crc engine. No dependencies.
package mcrc_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_ADDR_W = 2;

    // crc_mode codes
    localparam logic [1:0] MODE_CRC8  = 2'd0;
    localparam logic [1:0] MODE_CRC16 = 2'd1;
    localparam logic [1:0] MODE_CRC32 = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CRC_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ENABLE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CUSTOM_SEED = 2'd2;

    localparam logic [7:0]  POLY_CRC8  = 8'h07;
    localparam logic [15:0] POLY_CRC16 = 16'h1021;
    localparam logic [31:0] POLY_CRC32 = 32'h04C1_1DB7;
    localparam logic [7:0]  SEED_CRC8  = 8'h00;
    localparam logic [15:0] SEED_CRC16 = 16'hFFFF;
    localparam logic [31:0] SEED_CRC32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_frame;
        logic              last_byte;
        logic [CRC_W-1:0]  golden_crc;
    } in_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_raw;
        logic [CRC_W-1:0] crc_final;
        logic             frame_done;
        logic             crc_match;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       crc_mode;
        logic             custom_seed_enable;
        logic [CRC_W-1:0] custom_seed;
    } cfg_t;

    function automatic logic [7:0] fold8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ POLY_CRC8) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ POLY_CRC16) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] fold32(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {data, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ POLY_CRC32) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== src/mcrc_core.sv =====
// mcrc_core: byte-wide parallel xor network, seed selection, finalize and match.
// Depends on mcrc_pkg.
module mcrc_core
    import mcrc_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [CRC_W-1:0]  crc_cur,
    input  in_item_t          item,
    output out_item_t         result
);

    logic [CRC_W-1:0] seed;
    logic [CRC_W-1:0] base;
    logic [CRC_W-1:0] crc_new;
    logic [CRC_W-1:0] fin;
    logic [CRC_W-1:0] exp_masked;

    always_comb begin
        unique case (cfg.crc_mode)
            MODE_CRC8:  seed = {24'h0, SEED_CRC8};
            MODE_CRC16: seed = {16'h0, SEED_CRC16};
            default:    seed = SEED_CRC32;
        endcase
        if (cfg.custom_seed_enable) begin
            seed = cfg.custom_seed;
        end
        base = item.start_frame ? seed : crc_cur;

        // narrow modes only look at the low bits, so the register is cut to width here
        unique case (cfg.crc_mode)
            MODE_CRC8: begin
                crc_new    = {24'h0, fold8(base[7:0], item.data_byte)};
                fin        = crc_new;
                exp_masked = {24'h0, item.golden_crc[7:0]};
            end
            MODE_CRC16: begin
                crc_new    = {16'h0, fold16(base[15:0], item.data_byte)};
                fin        = crc_new;
                exp_masked = {16'h0, item.golden_crc[15:0]};
            end
            default: begin
                crc_new    = fold32(base, item.data_byte);
                fin        = ~crc_new;
                exp_masked = item.golden_crc;
            end
        endcase

        result.crc_raw    = crc_new;
        result.crc_final  = fin;
        result.frame_done = item.last_byte;
        result.crc_match  = item.last_byte && (fin == exp_masked);
    end

endmodule

// ===== src/multi_width_crc_engine.sv =====
// multi_width_crc_engine: top level with config registers, running crc register and
// a two-entry result buffer. Depends on mcrc_pkg and mcrc_core.
//
// Usage:
//   s_ channel: one message byte per transfer, with start_frame, last_byte and
//   golden_crc. m_ channel: one result per input transfer, in order, holding the
//   raw register, the finalized value, frame_done and crc_match.
//   cfg channel: cfg_addr selects crc_mode (0), custom_seed_enable (1) or
//   custom_seed (2); cfg_ready is always high. Write only while no result is pending.
//   Throughput: one byte per cycle while s_ready is high; the byte-wide xor fold
//   of the running crc register completes in the accept cycle, so back-to-back
//   bytes chain directly. Each result is registered before it shows on m_.
//   Stall: a result register plus one skid entry; s_ready drops only while both
//   hold results the receiver has not taken.
//   Reset: crc register cleared, mode CRC-32, standard seed, custom seed zero,
//   no result pending.
module multi_width_crc_engine
    import mcrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CRC_W-1:0]      cfg_data
);

    cfg_t             cfg_reg;
    logic [CRC_W-1:0] crc_reg;
    out_item_t        result;
    out_item_t        out_reg, out_next;
    out_item_t        skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             s_xfer;
    logic             m_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = out_valid_reg && m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    mcrc_core u_core (
        .cfg     (cfg_reg),
        .crc_cur (crc_reg),
        .item    (s_data),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_mode           <= MODE_CRC32;
            cfg_reg.custom_seed_enable <= 1'b0;
            cfg_reg.custom_seed        <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_CRC_MODE:    cfg_reg.crc_mode           <= cfg_data[1:0];
                REG_SEED_ENABLE: cfg_reg.custom_seed_enable <= cfg_data[0];
                REG_CUSTOM_SEED: cfg_reg.custom_seed        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (s_xfer) begin
            crc_reg <= result.crc_raw;
        end
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_xfer) begin
            out_valid_next = skid_valid_reg;
            out_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (s_xfer) begin
            // new result lands in the output stage unless it is still occupied
            if (!out_valid_next) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output stage empty");

    a_crc_tracks_newest: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (crc_reg == (skid_valid_reg ? skid_reg.crc_raw : out_reg.crc_raw)))
        else $error("running crc differs from newest buffered result");

    a_match_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_done) |-> !m_data.crc_match)
        else $error("crc_match set on a byte that does not end a frame");

    a_accept_fills_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> out_valid_reg)
        else $error("accepted byte left no result");

endmodule
